// ----- rtl/core/otpt_pkg.sv -----
// Shared types and codes for the one-shot and periodic timer table.
package otpt_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_ONCE  = 2'd0;
   localparam logic [1:0] KIND_EVERY = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // Result kinds.
   localparam logic [1:0] RES_ACCEPTED    = 2'd0;
   localparam logic [1:0] RES_TABLE_FULL  = 2'd1;
   localparam logic [1:0] RES_TASK_FIRED  = 2'd2;
   localparam logic [1:0] RES_NOTHING_DUE = 2'd3;

   // One timer entry as held in a cell.
   typedef struct packed {
      logic [31:0] deadline;
      logic [31:0] interval;
      logic [7:0]  id;
   } entry_type;

   // Per-cycle control broadcast to every cell of the chain.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/otpt_if.sv -----
// Valid/ready channel interfaces for the timer table requests and responses.
interface otpt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] time_value;
   logic [7:0]  task_id;

   modport source (output valid, kind, time_value, task_id, input ready);
   modport sink (input valid, kind, time_value, task_id, output ready);
endinterface

interface otpt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] fired_id;
   logic       last;

   modport source (output valid, result_kind, fired_id, last, input ready);
   modport sink (input valid, result_kind, fired_id, last, output ready);
endinterface

// ----- rtl/core/oneshot_periodic_timer_table.sv -----
// Top level of the one-shot and periodic timer table.
// Entries live in a chain of cells kept in insertion order, with the oldest entry in
// cell 0. A schedule beat appends at the first free cell. A tick beat walks the stored
// entries: in each step the single deadline comparator at the head of the chain
// examines cell 0, the whole chain moves down one cell, and an entry that stays (not
// due, or periodic with its deadline advanced) is written back behind the entries
// already handled, while a fired one-shot entry is dropped, which compacts the table.
// The closing cycle sends the final response beat. A request beat is taken, and every
// step of a tick walk proceeds, only while the response register is empty or being
// taken, so each response stall adds its cycles to the walk.
module oneshot_periodic_timer_table
   import otpt_pkg::*;
#(
   parameter int N_ENTRIES = 16
) (
   input logic     clock,
   input logic     reset,
   otpt_req_if.sink   req_ch,
   otpt_rsp_if.source rsp_ch
);

   localparam int CW = $clog2(N_ENTRIES + 1);

   typedef enum logic {ST_IDLE, ST_TICK} state_type;

   state_type   state_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] rem_ff;
   logic [31:0]   last_now_ff;
   logic          pend_valid_ff;
   logic [7:0]    pend_id_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_kind_ff;
   logic [7:0]    rsp_id_ff;
   logic          rsp_last_ff;

   entry_type     chain [N_ENTRIES+1];
   entry_type     head;
   entry_type     wr_entry;
   logic [CW-1:0] wr_index;
   cell_ctrl_type ctrl;

   logic can_out;
   logic accept;
   logic is_sched;
   logic full;
   logic append;
   logic due;
   logic drop;
   logic step;
   logic finish;

   // Handshake and step qualification.
   assign can_out  = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && can_out;
   assign accept   = req_ch.valid && req_ch.ready;
   assign is_sched = (req_ch.kind == KIND_ONCE) || (req_ch.kind == KIND_EVERY);
   assign full     = (count_ff == CW'(N_ENTRIES));
   assign append   = accept && is_sched && !full;

   assign head   = chain[0];
   assign due    = last_now_ff >= head.deadline;
   assign drop   = due && (head.interval == 32'd0);
   assign step   = (state_ff == ST_TICK) && can_out && (rem_ff != '0);
   assign finish = (state_ff == ST_TICK) && can_out && (rem_ff == '0);

   // Cell control: append at the first free cell, or write a kept head entry back
   // behind the entries already handled during a tick.
   always_comb begin
      ctrl.shift = step;
      ctrl.load  = append || (step && !drop);
      wr_index   = count_ff;
      wr_entry   = head;
      if (step) begin
         wr_index = count_ff - CW'(1);
         if (due) begin
            wr_entry.deadline = head.deadline + head.interval;
         end
      end else begin
         wr_entry.id = req_ch.task_id;
         if (req_ch.kind == KIND_EVERY) begin
            wr_entry.deadline = last_now_ff + req_ch.time_value;
            wr_entry.interval = req_ch.time_value;
         end else begin
            wr_entry.deadline = req_ch.time_value;
            wr_entry.interval = 32'd0;
         end
      end
   end

   // The chain of cells; the top cell takes an empty entry when shifting.
   assign chain[N_ENTRIES] = '0;

   for (genvar i = 0; i < N_ENTRIES; i++) begin : g_cell
      otpt_cell #(
         .CW    (CW),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .wr_index  (wr_index),
         .wr_entry  (wr_entry),
         .nbr_entry (chain[i+1]),
         .entry     (chain[i])
      );
   end

   // Sequencer, counters, pending fired id and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rem_ff        <= '0;
         last_now_ff   <= 32'd0;
         pend_valid_ff <= 1'b0;
         pend_id_ff    <= 8'd0;
         rsp_valid_ff  <= 1'b0;
         rsp_kind_ff   <= RES_ACCEPTED;
         rsp_id_ff     <= 8'd0;
         rsp_last_ff   <= 1'b0;
      end else begin
         if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && is_sched) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= full ? RES_TABLE_FULL : RES_ACCEPTED;
                  rsp_id_ff    <= 8'd0;
                  rsp_last_ff  <= 1'b1;
                  if (!full) begin
                     count_ff <= count_ff + CW'(1);
                  end
               end else if (accept && (req_ch.kind == KIND_TICK)) begin
                  last_now_ff   <= req_ch.time_value;
                  rem_ff        <= count_ff;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_TICK;
               end
            end
            ST_TICK: begin
               if (step) begin
                  rem_ff <= rem_ff - CW'(1);
                  if (drop) begin
                     count_ff <= count_ff - CW'(1);
                  end
                  if (due) begin
                     // A new firing means the held one is not the last beat.
                     pend_valid_ff <= 1'b1;
                     pend_id_ff    <= head.id;
                     if (pend_valid_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_kind_ff  <= RES_TASK_FIRED;
                        rsp_id_ff    <= pend_id_ff;
                        rsp_last_ff  <= 1'b0;
                     end
                  end
               end else if (finish) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_kind_ff   <= pend_valid_ff ? RES_TASK_FIRED : RES_NOTHING_DUE;
                  rsp_id_ff     <= pend_valid_ff ? pend_id_ff : 8'd0;
                  rsp_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_kind_ff;
   assign rsp_ch.fired_id    = rsp_id_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // The table never holds more entries than it has cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(N_ENTRIES))
      else $error("entry count exceeds table size");

   // Entries still to be examined are always a subset of the stored entries.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |-> (rem_ff <= count_ff))
      else $error("remaining entries exceed stored entries");

   // A schedule beat is answered in the next cycle with a single final beat.
   a_sched_resp: assert property (@(posedge clock) disable iff (reset)
      (accept && is_sched) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("schedule beat not answered");

   // Only a firing carries a nonzero id.
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff != RES_TASK_FIRED)) |-> (rsp_id_ff == 8'd0))
      else $error("nonzero id on a non-firing beat");

   // An accepted tick starts a table walk.
   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_ch.kind == KIND_TICK)) |=> (state_ff == ST_TICK))
      else $error("tick did not start a walk");

endmodule

// ----- rtl/core/otpt_cell.sv -----
// One storage cell of the timer chain: loads a new entry or takes its upper neighbor's.
module otpt_cell
   import otpt_pkg::*;
#(
   parameter int CW    = 5,
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [CW-1:0] wr_index,
   input  entry_type     wr_entry,
   input  entry_type     nbr_entry,
   output entry_type     entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // A directed load wins; otherwise the chain moves down by one cell.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load && (wr_index == CW'(INDEX))) begin
         entry_in = wr_entry;
      end else if (ctrl.shift) begin
         entry_in = nbr_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
